// ===== rtl/irc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package irc_pkg;

	localparam int PIX_W = 8;
	localparam int IDX_W = 10;
	localparam int AVG_W = 8;
	localparam int CFG_W = 11;
	localparam int CFG_IDX_W = 2;
	localparam int PIX_MAX = 255;

	localparam int MAX_COLUMNS_DEF = 1024;
	localparam int MAX_ROWS_DEF = 1024;

	localparam logic [CFG_W-1:0] WIDTH_RESET = 11'd640;
	localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

	localparam logic KIND_ROW = 1'b0;
	localparam logic KIND_COL = 1'b1;

	localparam int Q_DEPTH = 4;
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	typedef struct packed {
		logic [Q_CNT_W-1:0] count;
		logic               empty;
	} irc_q_status_t;

	function automatic int irc_max(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

	// Width of a sum of up to max(columns, rows) full-scale pixels.
	function automatic int irc_sum_w(input int mc, input int mr);
		return $clog2(PIX_MAX * irc_max(mc, mr) + 1);
	endfunction

	// Width that holds a pixel count from 1 up to max(columns, rows).
	function automatic int irc_n_w(input int mc, input int mr);
		return $clog2(irc_max(mc, mr) + 1);
	endfunction

	function automatic int irc_entry_w(input int mc, input int mr);
		return 2 + 2 * IDX_W + 2 * irc_sum_w(mc, mr);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/irc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface irc_pixel_if import irc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel;

	modport source (output valid, output pixel, input ready);
	modport sink (input valid, input pixel, output ready);
endinterface

interface irc_result_if import irc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             kind;
	logic [IDX_W-1:0] index;
	logic [AVG_W-1:0] average;
	logic             last;

	modport source (output valid, output kind, output index, output average, output last,
		input ready);
	modport sink (input valid, input kind, input index, input average, input last,
		output ready);
endinterface

interface irc_cfg_if import irc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/irc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module irc_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 1024
) (
	input  wire logic                                    clk,
	input  wire logic                                    we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                        wdata,
	input  wire logic                                    re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/irc_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module irc_fifo import irc_pkg::*; #(
	parameter int WIDTH = 58
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] pop_data,
	output irc_q_status_t         status
);

	localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

	logic [WIDTH-1:0]   mem_q [Q_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign pop_data     = mem_q[rd_ptr_q];
	assign status.count = count_q;
	assign status.empty = (count_q == '0);

endmodule

`default_nettype wire

// ===== rtl/irc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module irc_front import irc_pkg::*; #(
	parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
	parameter int MAX_ROWS = MAX_ROWS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	irc_pixel_if.sink      pix,
	irc_cfg_if.sink        cfg,
	input  wire irc_q_status_t q_stat,
	output logic           q_push,
	output logic [irc_entry_w(MAX_COLUMNS, MAX_ROWS)-1:0] q_data,
	output logic [irc_n_w(MAX_COLUMNS, MAX_ROWS)-1:0]     w_eff,
	output logic [irc_n_w(MAX_COLUMNS, MAX_ROWS)-1:0]     h_eff
);

	localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int N_W = irc_n_w(MAX_COLUMNS, MAX_ROWS);
	localparam int SUM_W = irc_sum_w(MAX_COLUMNS, MAX_ROWS);

	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [SUM_W-1:0] row_sum_q;

	logic             valid_s1;
	logic [PIX_W-1:0] px_s1;
	logic [COL_W-1:0] col_s1;
	logic [ROW_W-1:0] row_s1;
	logic             first_row_s1;
	logic             row_end_s1;
	logic             last_row_s1;
	logic [SUM_W-1:0] row_sum_s1;

	logic             fwd_valid_q;
	logic [COL_W-1:0] fwd_addr_q;
	logic [SUM_W-1:0] fwd_data_q;

	logic             accept;
	logic             cfg_write;
	logic             stale;
	logic [COL_W-1:0] c_cur;
	logic [ROW_W-1:0] r_cur;
	logic             row_end;
	logic             last_row;
	logic [SUM_W-1:0] row_sum_nx;
	logic [SUM_W-1:0] ram_rdata;
	logic [SUM_W-1:0] col_old;
	logic [SUM_W-1:0] col_new;

	// A size of zero acts as one, an oversized one as the largest supported.
	always_comb begin
		if (width_q == '0) begin
			w_eff = N_W'(1);
		end else if (int'(width_q) > MAX_COLUMNS) begin
			w_eff = N_W'(MAX_COLUMNS);
		end else begin
			w_eff = N_W'(width_q);
		end
		if (height_q == '0) begin
			h_eff = N_W'(1);
		end else if (int'(height_q) > MAX_ROWS) begin
			h_eff = N_W'(MAX_ROWS);
		end else begin
			h_eff = N_W'(height_q);
		end
	end

	assign cfg.ready = 1'b1;
	assign cfg_write = cfg.valid && cfg.ready;

	// Room is kept for the word already in the first stage.
	assign q_push = valid_s1 && (row_end_s1 || last_row_s1);
	assign pix.ready = ((Q_CNT_W + 1)'(q_stat.count) + (Q_CNT_W + 1)'(q_push))
		< (Q_CNT_W + 1)'(Q_DEPTH);
	assign accept = pix.valid && pix.ready;

	assign stale = (N_W'(col_q) >= w_eff) || (N_W'(row_q) >= h_eff);
	assign c_cur = stale ? '0 : col_q;
	assign r_cur = stale ? '0 : row_q;
	assign row_end = (N_W'(c_cur) == w_eff - N_W'(1));
	assign last_row = (N_W'(r_cur) == h_eff - N_W'(1));
	assign row_sum_nx = (stale ? '0 : row_sum_q) + SUM_W'(pix.pixel);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= WIDTH_RESET;
			height_q  <= HEIGHT_RESET;
			col_q     <= '0;
			row_q     <= '0;
			row_sum_q <= '0;
			valid_s1  <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (cfg_write) begin
				case (cfg.index)
					REG_WIDTH: begin
						width_q   <= cfg.data;
						col_q     <= '0;
						row_q     <= '0;
						row_sum_q <= '0;
					end
					REG_HEIGHT: begin
						height_q  <= cfg.data;
						col_q     <= '0;
						row_q     <= '0;
						row_sum_q <= '0;
					end
					default: begin
					end
				endcase
			end else if (accept) begin
				if (row_end) begin
					row_sum_q <= '0;
					col_q     <= '0;
					row_q     <= last_row ? '0 : r_cur + 1'b1;
				end else begin
					row_sum_q <= row_sum_nx;
					col_q     <= c_cur + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1        <= pix.pixel;
			col_s1       <= c_cur;
			row_s1       <= r_cur;
			first_row_s1 <= (r_cur == '0);
			row_end_s1   <= row_end;
			last_row_s1  <= last_row;
			row_sum_s1   <= row_sum_nx;
		end
	end

	irc_ram #(
		.WIDTH (SUM_W),
		.DEPTH (MAX_COLUMNS)
	) u_col_ram (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (col_s1),
		.wdata (col_new),
		.re    (accept),
		.raddr (c_cur),
		.rdata (ram_rdata)
	);

	// The memory read of a pixel can coincide with the write of the pixel before it
	// in the same column, as happens in narrow frames. The last write is kept aside
	// and wins over the memory data when the column matches.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (valid_s1) begin
			fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			fwd_addr_q <= col_s1;
			fwd_data_q <= col_new;
		end
	end

	assign col_old = (fwd_valid_q && (fwd_addr_q == col_s1)) ? fwd_data_q : ram_rdata;
	assign col_new = first_row_s1 ? SUM_W'(px_s1) : col_old + SUM_W'(px_s1);

	assign q_data = {row_end_s1, last_row_s1, IDX_W'(row_s1), IDX_W'(col_s1),
		row_sum_s1, col_new};

endmodule

`default_nettype wire

// ===== rtl/irc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module irc_back import irc_pkg::*; #(
	parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
	parameter int MAX_ROWS = MAX_ROWS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire irc_q_status_t q_stat,
	input  wire logic [irc_entry_w(MAX_COLUMNS, MAX_ROWS)-1:0] q_data,
	output logic           q_pop,
	input  wire logic [irc_n_w(MAX_COLUMNS, MAX_ROWS)-1:0]     w_eff,
	input  wire logic [irc_n_w(MAX_COLUMNS, MAX_ROWS)-1:0]     h_eff,
	irc_result_if.source   res
);

	localparam int N_W = irc_n_w(MAX_COLUMNS, MAX_ROWS);
	localparam int SUM_W = irc_sum_w(MAX_COLUMNS, MAX_ROWS);
	localparam int NUM_W = SUM_W + 2;
	localparam int DEN_W = N_W + 1;
	localparam int CMP_W = irc_max(NUM_W, DEN_W + AVG_W - 1);
	localparam int STEP_W = (AVG_W > 1) ? $clog2(AVG_W) : 1;

	typedef enum logic [1:0] {
		B_IDLE,
		B_DIV,
		B_DONE
	} back_state_t;

	back_state_t       state_q;
	logic [STEP_W-1:0] step_q;
	logic              col_pend_q;
	logic              kind_q;
	logic [IDX_W-1:0]  idx_q;
	logic              last_q;
	logic [IDX_W-1:0]  col_idx_q;
	logic [SUM_W-1:0]  col_sum_q;
	logic [CMP_W-1:0]  rem_q;
	logic [CMP_W-1:0]  dsh_q;
	logic [AVG_W-1:0]  quo_q;

	logic              out_valid_q;
	logic              out_kind_q;
	logic [IDX_W-1:0]  out_index_q;
	logic [AVG_W-1:0]  out_average_q;
	logic              out_last_q;

	logic              e_row_en;
	logic              e_col_en;
	logic [IDX_W-1:0]  e_row_idx;
	logic [IDX_W-1:0]  e_col_idx;
	logic [SUM_W-1:0]  e_row_sum;
	logic [SUM_W-1:0]  e_col_sum;

	logic [SUM_W-1:0]  ld_sum;
	logic [N_W-1:0]    ld_n;
	logic [CMP_W-1:0]  ld_num;
	logic [CMP_W-1:0]  ld_den;
	logic              out_free;
	logic              out_load;
	logic              ge;

	assign {e_row_en, e_col_en, e_row_idx, e_col_idx, e_row_sum, e_col_sum} = q_data;

	// The next division is either the head word's first mean or the pending
	// column mean of the word in hand.
	always_comb begin
		if (state_q == B_IDLE) begin
			ld_sum = e_row_en ? e_row_sum : e_col_sum;
			ld_n   = e_row_en ? w_eff : h_eff;
		end else begin
			ld_sum = col_sum_q;
			ld_n   = h_eff;
		end
	end

	// Rounded mean as (2*sum + n) div (2*n), one quotient bit per cycle.
	assign ld_num = CMP_W'({ld_sum, 1'b0}) + CMP_W'(ld_n);
	assign ld_den = CMP_W'({ld_n, 1'b0}) << (AVG_W - 1);
	assign ge = (rem_q >= dsh_q);

	assign q_pop = (state_q == B_IDLE) && !q_stat.empty;
	assign out_free = !out_valid_q || res.ready;
	assign out_load = (state_q == B_DONE) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= B_IDLE;
			step_q        <= '0;
			col_pend_q    <= 1'b0;
			kind_q        <= KIND_ROW;
			idx_q         <= '0;
			last_q        <= 1'b0;
			col_idx_q     <= '0;
			col_sum_q     <= '0;
			rem_q         <= '0;
			dsh_q         <= '0;
			quo_q         <= '0;
			out_valid_q   <= 1'b0;
			out_kind_q    <= KIND_ROW;
			out_index_q   <= '0;
			out_average_q <= '0;
			out_last_q    <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (!q_stat.empty) begin
						col_pend_q <= e_row_en && e_col_en;
						kind_q     <= e_row_en ? KIND_ROW : KIND_COL;
						idx_q      <= e_row_en ? e_row_idx : e_col_idx;
						last_q     <= !(e_row_en && e_col_en);
						col_idx_q  <= e_col_idx;
						col_sum_q  <= e_col_sum;
						rem_q      <= ld_num;
						dsh_q      <= ld_den;
						step_q     <= '0;
						state_q    <= B_DIV;
					end
				end
				B_DIV: begin
					if (ge) begin
						rem_q <= rem_q - dsh_q;
					end
					quo_q  <= {quo_q[AVG_W-2:0], ge};
					dsh_q  <= dsh_q >> 1;
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(AVG_W - 1)) begin
						state_q <= B_DONE;
					end
				end
				B_DONE: begin
					if (out_free) begin
						out_kind_q    <= kind_q;
						out_index_q   <= idx_q;
						out_average_q <= quo_q;
						out_last_q    <= last_q;
						if (col_pend_q) begin
							col_pend_q <= 1'b0;
							kind_q     <= KIND_COL;
							idx_q      <= col_idx_q;
							last_q     <= 1'b1;
							rem_q      <= ld_num;
							dsh_q      <= ld_den;
							step_q     <= '0;
							state_q    <= B_DIV;
						end else begin
							state_q <= B_IDLE;
						end
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	assign res.valid   = out_valid_q;
	assign res.kind    = out_kind_q;
	assign res.index   = out_index_q;
	assign res.average = out_average_q;
	assign res.last    = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/image_row_column_mean.sv =====
// Channel   Dir   Word fields                      Accepted when
// pix       in    pixel[7:0]                       pix.valid && pix.ready
// res       out   kind, index[9:0], average[7:0],  res.valid && res.ready
//                 last
// cfg       in    index[1:0], data[10:0]           cfg.valid && cfg.ready
//
// Pixels are taken one per cycle while the word queue between the front and the
// mean divider has room. The back end loads the first mean of a word, works out
// its 8 quotient bits and hands it off; the column mean that follows a row mean
// is loaded at that hand-off, so in the last row, and at each row end, the
// divider sets the pace.
// A result waits in the output register while the divider works on the next one.
// Reset clears all control state; the column sum memory needs no clearing pass,
// since the first row of every frame writes each entry and ignores what it read.
`timescale 1ns / 1ps
`default_nettype none

module image_row_column_mean import irc_pkg::*; #(
	parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
	parameter int MAX_ROWS = MAX_ROWS_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	irc_pixel_if.sink     pix,
	irc_cfg_if.sink       cfg,
	irc_result_if.source  res
);

	localparam int N_W = irc_n_w(MAX_COLUMNS, MAX_ROWS);
	localparam int ENTRY_W = irc_entry_w(MAX_COLUMNS, MAX_ROWS);

	irc_q_status_t      q_stat;
	logic               q_push;
	logic               q_pop;
	logic [ENTRY_W-1:0] q_push_data;
	logic [ENTRY_W-1:0] q_pop_data;
	logic [N_W-1:0]     w_eff;
	logic [N_W-1:0]     h_eff;

	irc_front #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.MAX_ROWS    (MAX_ROWS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix),
		.cfg    (cfg),
		.q_stat (q_stat),
		.q_push (q_push),
		.q_data (q_push_data),
		.w_eff  (w_eff),
		.h_eff  (h_eff)
	);

	irc_fifo #(
		.WIDTH (ENTRY_W)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.pop       (q_pop),
		.pop_data  (q_pop_data),
		.status    (q_stat)
	);

	irc_back #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.MAX_ROWS    (MAX_ROWS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_stat (q_stat),
		.q_data (q_pop_data),
		.q_pop  (q_pop),
		.w_eff  (w_eff),
		.h_eff  (h_eff),
		.res    (res)
	);

	// The front only pushes a word when the queue has a free slot.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (q_stat.count < Q_CNT_W'(Q_DEPTH)))
		else $error("word queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("word queue underflow");

	// Pixel intake stalls only when the queue is close to full.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!pix.ready |-> (q_stat.count >= Q_CNT_W'(Q_DEPTH - 1)))
		else $error("pixel intake stalled with room in the queue");

	// A word pushed in one cycle is seen by the queue count in the next.
	a_push_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && !q_pop) |=> (q_stat.count == $past(q_stat.count) + 1'b1))
		else $error("pushed word not counted");

endmodule

`default_nettype wire

// ===== test/tb_image_row_column_mean.sv =====
`timescale 1ns / 1ps

module tb_image_row_column_mean;
	import irc_pkg::*;

	localparam int MAX_COLS = MAX_COLUMNS_DEF;
	localparam int MAX_LINES = MAX_ROWS_DEF;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd2;
	localparam int IDLE_PCT = 26;
	localparam int DRAIN_CYCLES = 60;
	localparam int REPORT_LIMIT = 10;
	localparam int RANDOM_PIXELS = 400;
	localparam int BACKPRESSURE_CYCLES = 400;

	typedef struct packed {
		logic             kind;
		logic [IDX_W-1:0] index;
		logic [AVG_W-1:0] average;
		logic             last;
	} mean_word_t;

	logic clk = 1'b0;
	logic arst_n;

	irc_pixel_if  pix_if ();
	irc_cfg_if    cfg_if ();
	irc_result_if res_if ();

	image_row_column_mean dut (
		.clk(clk),
		.arst_n(arst_n),
		.pix(pix_if),
		.cfg(cfg_if),
		.res(res_if)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shadow copy of the block's registers and accumulators.
	logic [CFG_W-1:0] model_width;
	logic [CFG_W-1:0] model_height;
	int unsigned col_total [MAX_COLS];
	int unsigned row_total;
	int unsigned col_at;
	int unsigned row_at;
	mean_word_t pending_means [$];

	bit quiet_mode = 1'b0;
	int out_hold_cycles = 0;
	int n_pixels = 0;
	int n_row_means = 0;
	int n_col_means = 0;
	int n_cfg_writes = 0;
	int n_failures = 0;

	function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned limit);
		if (v == '0)
			return 1;
		if (v > limit)
			return limit;
		return v;
	endfunction

	function automatic logic [AVG_W-1:0] half_up_mean(input int unsigned total, input int unsigned n);
		int unsigned q;
		q = (2 * total + n) / (2 * n);
		return q[AVG_W-1:0];
	endfunction

	function automatic logic [PIX_W-1:0] rand_pixel();
		int unsigned pick;
		pick = $urandom_range(7);
		if (pick == 0)
			return '0;
		if (pick == 1)
			return PIX_W'(PIX_MAX);
		return PIX_W'($urandom_range(PIX_MAX));
	endfunction

	task automatic log_failure(input string msg);
		n_failures++;
		if (n_failures <= REPORT_LIMIT)
			$display("%s", msg);
	endtask

	task automatic predict_means(input logic [PIX_W-1:0] px);
		int unsigned w;
		int unsigned h;
		bit row_end;
		bit last_row;
		mean_word_t m;
		w = clamp_dim(model_width, MAX_COLS);
		h = clamp_dim(model_height, MAX_LINES);
		if (col_at >= w || row_at >= h) begin
			row_total = 0;
			col_at = 0;
			row_at = 0;
		end
		row_end = (col_at == w - 1);
		last_row = (row_at == h - 1);
		row_total += px;
		// Row zero overwrites the column sums, so nothing stale is ever read.
		if (row_at == 0)
			col_total[col_at] = px;
		else
			col_total[col_at] += px;
		if (row_end) begin
			m.kind = KIND_ROW;
			m.index = row_at[IDX_W-1:0];
			m.average = half_up_mean(row_total, w);
			m.last = !last_row;
			pending_means.push_back(m);
		end
		if (last_row) begin
			m.kind = KIND_COL;
			m.index = col_at[IDX_W-1:0];
			m.average = half_up_mean(col_total[col_at], h);
			m.last = 1'b1;
			pending_means.push_back(m);
		end
		if (row_end) begin
			row_total = 0;
			col_at = 0;
			row_at = last_row ? 0 : row_at + 1;
		end else begin
			col_at++;
		end
	endtask

	task automatic send_pixel(input logic [PIX_W-1:0] px);
		while (!quiet_mode && $urandom_range(99) < IDLE_PCT)
			@(negedge clk);
		pix_if.valid = 1'b1;
		pix_if.pixel = px;
		do
			@(posedge clk);
		while (!pix_if.ready);
		predict_means(px);
		n_pixels++;
		@(negedge clk);
		pix_if.valid = 1'b0;
	endtask

	task automatic send_pixels(input int count);
		repeat (count)
			send_pixel(rand_pixel());
	endtask

	// Registers change only once the block has gone quiet, including pixels
	// that produce no mean and may still sit in the queue.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		while (pending_means.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES)
			@(negedge clk);
		cfg_if.valid = 1'b1;
		cfg_if.index = idx;
		cfg_if.data = value;
		do
			@(posedge clk);
		while (!cfg_if.ready);
		if (idx == REG_WIDTH)
			model_width = value;
		if (idx == REG_HEIGHT)
			model_height = value;
		if (idx == REG_WIDTH || idx == REG_HEIGHT) begin
			row_total = 0;
			col_at = 0;
			row_at = 0;
		end
		n_cfg_writes++;
		@(negedge clk);
		cfg_if.valid = 1'b0;
	endtask

	task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
	endtask

	task automatic test_reset_width();
		// A short run at the power-up size stays inside the first row, so no mean appears.
		send_pixels(64);
	endtask

	task automatic test_rounding();
		set_frame(11'd2, 11'd2);
		send_pixel(8'd0);
		send_pixel(8'd1);
		send_pixel(8'd255);
		send_pixel(8'd254);
	endtask

	task automatic test_zero_size();
		// Zero width and height act as one, so every pixel closes a frame.
		set_frame(11'd0, 11'd0);
		send_pixel(8'd0);
		send_pixel(8'd255);
		send_pixel(8'd128);
		send_pixel(8'd1);
	endtask

	task automatic test_restart_on_write();
		set_frame(11'd3, 11'd3);
		send_pixels(5);
		// A write to an unused index leaves the frame running.
		write_reg(REG_SPARE, 11'h7FF);
		send_pixels(2);
		// This write drops the partial frame.
		write_reg(REG_HEIGHT, 11'd2);
		send_pixels(6);
	endtask

	task automatic test_widest_row();
		// An oversized width acts as the widest row, so a single-row frame gives
		// a column mean per pixel and no early row end.
		set_frame(11'd1025, 11'd1);
		send_pixels(40);
		set_frame(11'h7FF, 11'd1);
		repeat (20)
			send_pixel(PIX_W'(PIX_MAX));
	endtask

	task automatic test_tallest_column();
		// An oversized height acts as the tallest frame, so one-pixel rows give
		// only row means this early in the frame.
		set_frame(11'd1, 11'd1025);
		send_pixels(40);
		set_frame(11'd1, 11'h7FF);
		repeat (20)
			send_pixel(PIX_W'(PIX_MAX));
	endtask

	task automatic test_output_backpressure();
		set_frame(11'd1, 11'd1);
		out_hold_cycles = BACKPRESSURE_CYCLES;
		send_pixels(40);
	endtask

	task automatic test_random_frames();
		int start;
		int phase;
		int burst;
		int unsigned frame_size;
		logic [CFG_W-1:0] w;
		logic [CFG_W-1:0] h;
		start = n_pixels;
		phase = 0;
		while (n_pixels - start < RANDOM_PIXELS) begin
			quiet_mode = (phase % 8 == 3) || (phase % 8 == 4);
			w = ($urandom_range(9) == 0) ? CFG_W'($urandom_range(40)) : CFG_W'($urandom_range(1, 8));
			h = ($urandom_range(9) == 0) ? CFG_W'($urandom_range(12)) : CFG_W'($urandom_range(1, 6));
			set_frame(w, h);
			frame_size = clamp_dim(w, MAX_COLS) * clamp_dim(h, MAX_LINES);
			burst = $urandom_range(1, 3) * frame_size;
			if (burst > RANDOM_PIXELS - (n_pixels - start))
				burst = RANDOM_PIXELS - (n_pixels - start);
			send_pixels(burst);
			// Now and then leave a frame unfinished for the next write to cut off.
			if ($urandom_range(3) == 0) begin
				burst = $urandom_range(1, frame_size);
				if (burst > RANDOM_PIXELS - (n_pixels - start))
					burst = RANDOM_PIXELS - (n_pixels - start);
				send_pixels(burst);
			end
			phase++;
		end
		quiet_mode = 1'b0;
	endtask

	initial begin : result_sink
		res_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (out_hold_cycles > 0) begin
				res_if.ready = 1'b0;
				out_hold_cycles--;
			end else begin
				res_if.ready = quiet_mode || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	initial begin : result_check
		mean_word_t got;
		mean_word_t want;
		forever begin
			@(posedge clk);
			if (arst_n && res_if.valid && res_if.ready) begin
				got.kind = res_if.kind;
				got.index = res_if.index;
				got.average = res_if.average;
				got.last = res_if.last;
				if (pending_means.size() == 0) begin
					log_failure($sformatf("unexpected word: kind %0d index %0d average %0d last %0d",
						got.kind, got.index, got.average, got.last));
				end else begin
					want = pending_means.pop_front();
					if (got !== want)
						log_failure($sformatf(
							"mismatch: expected kind %0d index %0d average %0d last %0d, got kind %0d index %0d average %0d last %0d",
							want.kind, want.index, want.average, want.last,
							got.kind, got.index, got.average, got.last));
					else if (got.kind == KIND_ROW)
						n_row_means++;
					else
						n_col_means++;
				end
			end
		end
	end

	initial begin : watchdog
		#2_000_000;
		$display("image_row_column_mean regression: fail");
		$finish;
	end

	initial begin : stimulus
		arst_n = 1'b0;
		pix_if.valid = 1'b0;
		pix_if.pixel = '0;
		cfg_if.valid = 1'b0;
		cfg_if.index = '0;
		cfg_if.data = '0;
		model_width = WIDTH_RESET;
		model_height = HEIGHT_RESET;
		row_total = 0;
		col_at = 0;
		row_at = 0;
		foreach (col_total[i])
			col_total[i] = 0;
		repeat (5)
			@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_width();
		test_rounding();
		test_zero_size();
		test_restart_on_write();
		test_widest_row();
		test_tallest_column();
		test_output_backpressure();
		test_random_frames();

		while (pending_means.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES)
			@(negedge clk);

		$display("Sent %0d pixels over %0d register writes, from 1x1 frames to oversized widths and heights.",
			n_pixels, n_cfg_writes);
		$display("Matched %0d row means and %0d column means; %0d failures.",
			n_row_means, n_col_means, n_failures);
		if (n_failures == 0)
			$display("image_row_column_mean regression: pass");
		else
			$display("image_row_column_mean regression: fail");
		$finish;
	end

endmodule

// ===== image_row_column_mean.f =====
rtl/irc_pkg.sv
rtl/irc_if.sv
rtl/irc_ram.sv
rtl/irc_fifo.sv
rtl/irc_front.sv
rtl/irc_back.sv
rtl/image_row_column_mean.sv
test/tb_image_row_column_mean.sv
